FILE: rtl/core/sll_pkg.sv
`default_nettype none
package sll_pkg;

  localparam int LINE_BITS = 32;
  localparam int CHAR_W    = 21;
  localparam int KW_STATES = 139;
  localparam logic [7:0] TRIE_INIT = 8'd255;
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

  typedef enum logic [2:0] {
    AUT_START   = 3'd0,
    AUT_UNKNOWN = 3'd1,
    AUT_ID      = 3'd2,
    AUT_KEYWORD = 3'd3,
    AUT_STRING  = 3'd5
  } aut_t;

  typedef enum logic [1:0] {
    PH_BEGIN = 2'd0,
    PH_BODY  = 2'd1,
    PH_END   = 2'd2
  } phase_t;

  localparam logic [3:0] TK_END     = 4'd0;
  localparam logic [3:0] TK_UNKNOWN = 4'd1;
  localparam logic [3:0] TK_IDENT   = 4'd2;
  localparam logic [3:0] TK_STRING  = 4'd3;
  localparam logic [3:0] TK_COMMA   = 4'd4;
  localparam logic [3:0] TK_COLON   = 4'd5;
  localparam logic [3:0] TK_LBRACE  = 4'd6;
  localparam logic [3:0] TK_RBRACE  = 4'd7;
  localparam logic [3:0] TK_KEYWORD = 4'd8;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_KEYWORD  = 2'd1;
  localparam logic [1:0] ERR_PERCENT  = 2'd2;
  localparam logic [1:0] ERR_STRING   = 2'd3;

  // one result item
  typedef struct packed {
    logic                 item_kind;
    logic [3:0]           token_kind;
    logic [4:0]           keyword_number;
    logic [1:0]           error_code;
    logic [LINE_BITS-1:0] token_line;
    logic [CHAR_W-1:0]    payload_char;
    logic                 last_of_run;
  } res_t;

  // classified character passed from front to back
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              is_end;
    logic              space;
    logic              other;
    logic              percent;
    logic              after_pct;
    logic              id_begin;
    logic              id_body;
    logic              delim;
    logic              quote;
    logic [7:0]        init_state;
  } cls_t;

  // trie entry: up to 3 symbols, keyword, exact flag, next
  typedef struct packed {
    logic [7:0] s0;
    logic [7:0] s1;
    logic [7:0] s2;
    logic [4:0] kw;
    logic       exact;
    logic [7:0] nxt;
  } trie_t;

  function automatic trie_t te(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                               input logic [4:0] k, input logic x, input logic [7:0] n);
    trie_t t;
    t.s0 = a; t.s1 = b; t.s2 = c; t.kw = k; t.exact = x; t.nxt = n;
    return t;
  endfunction

  function automatic trie_t trie_rom(input logic [7:0] s);
    trie_t t;
    t = te(8'h0, 8'h0, 8'h0, 5'd0, 1'b0, 8'd0);
    case (s)
      8'd0:   t = te("c", 0, 0, 0, 0, 1);
      8'd1:   t = te("t", 0, 0, 0, 0, 2);
      8'd2:   t = te("i", 0, 0, 0, 0, 3);
      8'd3:   t = te("o", 0, 0, 0, 0, 4);
      8'd4:   t = te("n", 0, 0, 0, 0, 5);
      8'd5:   t = te(0, 0, 0, 0, 1, 0);
      8'd6:   t = te("l", "o", 0, 2, 0, 7);
      8'd7:   t = te("a", 0, 0, 1, 0, 9);
      8'd8:   t = te("d", "m", 0, 2, 0, 10);
      8'd9:   t = te("s", 0, 0, 1, 0, 12);
      8'd10:  t = te("e", 0, 0, 2, 0, 13);
      8'd11:  t = te("m", 0, 0, 4, 0, 14);
      8'd12:  t = te("s", 0, 0, 1, 0, 15);
      8'd13:  t = te("s", 0, 0, 2, 0, 16);
      8'd14:  t = te("e", 0, 0, 4, 0, 17);
      8'd15:  t = te("_", 0, 0, 1, 0, 18);
      8'd16:  t = te("_", 0, 0, 2, 1, 19);
      8'd17:  t = te("n", 0, 0, 4, 0, 20);
      8'd18:  t = te("m", 0, 0, 1, 0, 21);
      8'd19:  t = te("t", 0, 0, 3, 0, 22);
      8'd20:  t = te("t", 0, 0, 4, 0, 23);
      8'd21:  t = te("e", 0, 0, 1, 0, 24);
      8'd22:  t = te("y", 0, 0, 3, 0, 25);
      8'd23:  t = te("s", 0, 0, 4, 0, 26);
      8'd24:  t = te("m", 0, 0, 1, 0, 27);
      8'd25:  t = te("p", 0, 0, 3, 0, 28);
      8'd26:  t = te(0, 0, 0, 4, 1, 0);
      8'd27:  t = te("b", 0, 0, 1, 0, 29);
      8'd28:  t = te("e", 0, 0, 3, 0, 30);
      8'd29:  t = te("e", 0, 0, 1, 0, 31);
      8'd30:  t = te(0, 0, 0, 3, 1, 0);
      8'd31:  t = te("r", 0, 0, 1, 0, 32);
      8'd32:  t = te("s", 0, 0, 1, 0, 33);
      8'd33:  t = te(0, 0, 0, 1, 1, 0);
      8'd34:  t = te("e", 0, 0, 5, 0, 35);
      8'd35:  t = te("l", 0, 0, 5, 0, 36);
      8'd36:  t = te("i", 0, 0, 5, 0, 37);
      8'd37:  t = te("m", 0, 0, 5, 0, 38);
      8'd38:  t = te("i", 0, 0, 5, 0, 39);
      8'd39:  t = te("t", 0, 0, 5, 0, 40);
      8'd40:  t = te("e", 0, 0, 5, 0, 41);
      8'd41:  t = te("r", 0, 0, 5, 0, 42);
      8'd42:  t = te("s", 0, 0, 5, 0, 43);
      8'd43:  t = te(0, 0, 0, 5, 1, 0);
      8'd44:  t = te("d", 0, 0, 7, 0, 45);
      8'd45:  t = te("e", 0, 0, 7, 0, 46);
      8'd46:  t = te("n", 0, 0, 7, 0, 47);
      8'd47:  t = te("t", 0, 0, 7, 0, 48);
      8'd48:  t = te("_", "s", 0, 7, 0, 49);
      8'd49:  t = te("n", 0, 0, 6, 0, 51);
      8'd50:  t = te(0, 0, 0, 7, 1, 0);
      8'd51:  t = te("a", 0, 0, 6, 0, 52);
      8'd52:  t = te("m", 0, 0, 6, 0, 53);
      8'd53:  t = te("e", 0, 0, 6, 0, 54);
      8'd54:  t = te(0, 0, 0, 6, 1, 0);
      8'd55:  t = te("e", 0, 0, 8, 0, 56);
      8'd56:  t = te("y", 0, 0, 8, 0, 57);
      8'd57:  t = te("w", 0, 0, 8, 0, 58);
      8'd58:  t = te("o", 0, 0, 8, 0, 59);
      8'd59:  t = te("r", 0, 0, 8, 0, 60);
      8'd60:  t = te("d", 0, 0, 8, 0, 61);
      8'd61:  t = te("s", 0, 0, 8, 0, 62);
      8'd62:  t = te(0, 0, 0, 8, 1, 0);
      8'd63:  t = te("u", 0, 0, 9, 0, 64);
      8'd64:  t = te("l", 0, 0, 9, 0, 65);
      8'd65:  t = te("t", 0, 0, 9, 0, 66);
      8'd66:  t = te("i", 0, 0, 9, 0, 67);
      8'd67:  t = te("l", 0, 0, 9, 0, 68);
      8'd68:  t = te("i", 0, 0, 9, 0, 69);
      8'd69:  t = te("n", 0, 0, 9, 0, 70);
      8'd70:  t = te("e", 0, 0, 9, 0, 71);
      8'd71:  t = te("d", 0, 0, 9, 0, 72);
      8'd72:  t = te(0, 0, 0, 9, 1, 0);
      8'd73:  t = te("e", "u", 0, 12, 0, 74);
      8'd74:  t = te("s", "w", 0, 10, 0, 76);
      8'd75:  t = te("m", 0, 0, 12, 0, 78);
      8'd76:  t = te("t", 0, 0, 10, 0, 79);
      8'd77:  t = te("l", 0, 0, 11, 0, 80);
      8'd78:  t = te("b", 0, 0, 12, 0, 81);
      8'd79:  t = te("e", 0, 0, 10, 0, 82);
      8'd80:  t = te("i", 0, 0, 11, 0, 83);
      8'd81:  t = te("e", 0, 0, 12, 0, 84);
      8'd82:  t = te("d", 0, 0, 10, 0, 85);
      8'd83:  t = te("n", 0, 0, 11, 0, 86);
      8'd84:  t = te("r", 0, 0, 12, 0, 87);
      8'd85:  t = te(0, 0, 0, 10, 1, 0);
      8'd86:  t = te("e", 0, 0, 11, 0, 88);
      8'd87:  t = te("s", 0, 0, 12, 0, 89);
      8'd88:  t = te("_", 0, 0, 11, 0, 90);
      8'd89:  t = te(0, 0, 0, 12, 1, 0);
      8'd90:  t = te("i", 0, 0, 11, 0, 91);
      8'd91:  t = te("s", 0, 0, 11, 0, 92);
      8'd92:  t = te("_", 0, 0, 11, 0, 93);
      8'd93:  t = te("l", 0, 0, 11, 0, 94);
      8'd94:  t = te("e", 0, 0, 11, 0, 95);
      8'd95:  t = te("x", 0, 0, 11, 0, 96);
      8'd96:  t = te("e", 0, 0, 11, 0, 97);
      8'd97:  t = te("m", 0, 0, 11, 0, 98);
      8'd98:  t = te(0, 0, 0, 11, 1, 0);
      8'd99:  t = te("c", "i", "t", 13, 0, 100);
      8'd100: t = te("a", 0, 0, 13, 0, 103);
      8'd101: t = te("n", 0, 0, 14, 0, 104);
      8'd102: t = te("r", 0, 0, 15, 0, 105);
      8'd103: t = te("n", 0, 0, 13, 0, 106);
      8'd104: t = te("g", 0, 0, 14, 0, 107);
      8'd105: t = te("i", 0, 0, 15, 0, 108);
      8'd106: t = te("e", 0, 0, 13, 0, 109);
      8'd107: t = te("l", 0, 0, 14, 0, 110);
      8'd108: t = te("n", 0, 0, 15, 0, 111);
      8'd109: t = te("r", 0, 0, 13, 0, 112);
      8'd110: t = te("e", 0, 0, 14, 0, 113);
      8'd111: t = te("g", 0, 0, 15, 0, 114);
      8'd112: t = te("_", 0, 0, 13, 0, 115);
      8'd113: t = te("_", 0, 0, 14, 0, 116);
      8'd114: t = te("s", 0, 0, 15, 0, 117);
      8'd115: t = te("n", 0, 0, 13, 0, 118);
      8'd116: t = te("l", 0, 0, 14, 0, 119);
      8'd117: t = te(0, 0, 0, 15, 1, 0);
      8'd118: t = te("a", 0, 0, 13, 0, 120);
      8'd119: t = te("i", 0, 0, 14, 0, 121);
      8'd120: t = te("m", 0, 0, 13, 0, 122);
      8'd121: t = te("n", 0, 0, 14, 0, 123);
      8'd122: t = te("e", 0, 0, 13, 0, 124);
      8'd123: t = te("e", 0, 0, 14, 0, 125);
      8'd124: t = te(0, 0, 0, 13, 1, 0);
      8'd125: t = te("d", 0, 0, 14, 0, 126);
      8'd126: t = te(0, 0, 0, 14, 1, 0);
      8'd127: t = te("o", 0, 0, 16, 0, 128);
      8'd128: t = te("k", 0, 0, 16, 0, 129);
      8'd129: t = te("e", 0, 0, 16, 0, 130);
      8'd130: t = te("n", 0, 0, 16, 0, 131);
      8'd131: t = te("_", 0, 0, 16, 0, 132);
      8'd132: t = te("f", 0, 0, 16, 0, 133);
      8'd133: t = te("i", 0, 0, 16, 0, 134);
      8'd134: t = te("e", 0, 0, 16, 0, 135);
      8'd135: t = te("l", 0, 0, 16, 0, 136);
      8'd136: t = te("d", 0, 0, 16, 0, 137);
      8'd137: t = te("s", 0, 0, 16, 0, 138);
      8'd138: t = te(0, 0, 0, 16, 1, 0);
      default: t = te(8'h0, 8'h0, 8'h0, 5'd0, 1'b0, 8'd0);
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/spec_language_lexer_top.sv
`default_nettype none
// Path: an accepted character is written into the queue; its results are registered into the output buffer on a step.
// Throughput: one character per cycle while out_ready is high and each step yields at most one result;
//   a step with two results holds the next step until the output buffer is taking its last result.
// Reset (rst_n, synchronous, low): start automaton, empty queue and buffer,
//   first_line_number = 1 and line counter = 1.
module spec_language_lexer_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [20:0]                in_text_char,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_item_kind,
  output logic [3:0]                      out_token_kind,
  output logic [4:0]                      out_keyword_number,
  output logic [1:0]                      out_error_code,
  output logic [sll_pkg::LINE_BITS-1:0]   out_token_line,
  output logic [20:0]                     out_payload_char,
  output logic                            out_last_of_run,
  input  wire logic                       cfg_we,
  input  wire logic [31:0]                cfg_wdata
);
  import sll_pkg::*;

  logic  q_push, q_full, q_empty, q_pop;
  cls_t  q_wdata, q_rdata;
  res_t  res;

  // front end: classify each character
  sll_front u_front (
    .in_valid(in_valid), .in_ready(in_ready),
    .in_text_char(in_text_char), .q_push(q_push), .q_data(q_wdata), .q_full(q_full)
  );

  // short queue decouples the classifier from the automata
  sll_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wdata(q_wdata), .full(q_full),
    .empty(q_empty), .pop(q_pop), .rdata(q_rdata)
  );

  // back end: automata, trie walk, line counter, output buffer
  sll_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .q_empty(q_empty), .q_data(q_rdata), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_res(res)
  );

  assign out_item_kind      = res.item_kind;
  assign out_token_kind     = res.token_kind;
  assign out_keyword_number = res.keyword_number;
  assign out_error_code     = res.error_code;
  assign out_token_line     = res.token_line;
  assign out_payload_char   = res.payload_char;
  assign out_last_of_run    = res.last_of_run;

endmodule
`default_nettype wire

FILE: rtl/core/sll_front.sv
`default_nettype none
module sll_front (
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [sll_pkg::CHAR_W-1:0] in_text_char,
  output logic                          q_push,
  output sll_pkg::cls_t                 q_data,
  input  wire logic                     q_full
);
  import sll_pkg::*;

  logic [7:0] c8;
  logic       low;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign low      = (in_text_char[CHAR_W-1:8] == '0);
  assign c8       = in_text_char[7:0];

  // classify the character
  always_comb begin
    q_data            = '0;
    q_data.ch         = in_text_char;
    q_data.is_end     = (in_text_char == '0);
    q_data.init_state = TRIE_INIT;
    if (low && c8 >= 8'd1 && c8 <= 8'd32) q_data.space = 1'b1;
    else if (low && c8 == "\"") q_data.quote = 1'b1;
    else if (low && c8 == "%") q_data.percent = 1'b1;
    else if (low && (c8 == "," || c8 == ":" || c8 == "{" || c8 == "}")) q_data.delim = 1'b1;
    else if (low && c8 >= "0" && c8 <= "9") q_data.id_body = 1'b1;
    else if (low && ((c8 >= "A" && c8 <= "Z") || c8 == "_" || (c8 >= "a" && c8 <= "z"))) begin
      q_data.id_begin = 1'b1;
      q_data.id_body  = 1'b1;
      q_data.after_pct = 1'b1;
      case (c8)
        "a": q_data.init_state = 8'd0;
        "c": q_data.init_state = 8'd6;
        "d": q_data.init_state = 8'd34;
        "i": q_data.init_state = 8'd44;
        "k": q_data.init_state = 8'd55;
        "m": q_data.init_state = 8'd63;
        "n": q_data.init_state = 8'd73;
        "s": q_data.init_state = 8'd99;
        "t": q_data.init_state = 8'd127;
        default: q_data.after_pct = 1'b0;
      endcase
    end else if (!q_data.is_end) q_data.other = 1'b1;
  end

endmodule
`default_nettype wire

FILE: rtl/core/sll_fifo.sv
`default_nettype none
module sll_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sll_pkg::cls_t wdata,
  output logic               full,
  output logic               empty,
  input  wire logic          pop,
  output sll_pkg::cls_t      rdata
);
  import sll_pkg::*;

  cls_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");

endmodule
`default_nettype wire

FILE: rtl/core/sll_back.sv
`default_nettype none
module sll_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [31:0]                   cfg_wdata,
  input  wire logic                          q_empty,
  input  wire sll_pkg::cls_t                 q_data,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output sll_pkg::res_t                      out_res
);
  import sll_pkg::*;

  aut_t                 aut_r, aut_nxt;
  phase_t               ph_r, ph_nxt;
  logic [7:0]           trie_r, trie_nxt;
  logic [5:0]           pkc_r, pkc_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt, lsl_r, lsl_nxt, load_val;
  logic [31:0]          first_r;

  // two-entry output buffer: slot 0 is shown
  res_t       ob_r [2];
  logic [1:0] ocnt_r;
  res_t       r0, r1;
  logic [1:0] nres;
  logic       step;

  trie_t e;
  trie_t ie, he;
  logic  hit;
  logic [7:0] hs;
  logic [1:0] hy;
  logic       used;
  cls_t       d;
  logic       pop_out;

  assign d        = q_data;
  assign out_valid = (ocnt_r != 2'd0);
  assign out_res   = ob_r[0];
  assign pop_out   = out_valid && out_ready;
  // take a new item when the buffer will have room for two
  assign step      = !q_empty && (ocnt_r == 2'd0 || (ocnt_r == 2'd1 && pop_out));
  assign q_pop     = step;

  if (LINE_BITS >= 32) begin : g_ld
    assign load_val = LINE_BITS'(first_r);
  end else begin : g_ld
    assign load_val = (first_r > 32'(LINE_MAX)) ? LINE_MAX : first_r[LINE_BITS-1:0];
  end

  function automatic res_t mk(input logic ik, input logic [3:0] k, input logic [4:0] kw,
                              input logic [1:0] er, input logic [LINE_BITS-1:0] ln,
                              input logic [CHAR_W-1:0] p);
    res_t r;
    r.item_kind = ik; r.token_kind = k; r.keyword_number = kw; r.error_code = er;
    r.token_line = ln; r.payload_char = p; r.last_of_run = 1'b0;
    return r;
  endfunction

  always_comb begin
    e  = trie_rom(trie_r);
    hit = 1'b0;
    hy  = 2'd0;
    if (e.s0 != 8'd0 && d.ch == CHAR_W'(e.s0)) begin
      hit = 1'b1; hy = 2'd0;
    end else if (e.s0 != 8'd0 && e.s1 != 8'd0 && d.ch == CHAR_W'(e.s1)) begin
      hit = 1'b1; hy = 2'd1;
    end else if (e.s0 != 8'd0 && e.s1 != 8'd0 && e.s2 != 8'd0 && d.ch == CHAR_W'(e.s2)) begin
      hit = 1'b1; hy = 2'd2;
    end
    hs = e.nxt + {6'd0, hy};
    ie = trie_rom(d.init_state);
    he = trie_rom(hs);
  end

  // one step of the lexer
  always_comb begin
    aut_nxt  = aut_r;
    ph_nxt   = ph_r;
    trie_nxt = trie_r;
    pkc_nxt  = pkc_r;
    line_nxt = line_r;
    lsl_nxt  = lsl_r;
    nres     = 2'd0;
    r0       = '0;
    r1       = '0;
    used     = 1'b0;
    if (d.is_end) begin
      unique case (aut_r)
        AUT_UNKNOWN: begin r0 = mk(1, TK_UNKNOWN, 0, ERR_NONE, lsl_r, 0); nres = 2'd1; end
        AUT_ID:      begin r0 = mk(1, TK_IDENT, 0, ERR_NONE, lsl_r, 0); nres = 2'd1; end
        AUT_KEYWORD: begin
          if (trie_r >= 8'(KW_STATES)) r0 = mk(1, TK_UNKNOWN, 0, ERR_PERCENT, lsl_r, 0);
          else r0 = mk(1, TK_KEYWORD, pkc_r[4:0], pkc_r[5] ? ERR_KEYWORD : ERR_NONE, lsl_r, 0);
          nres = 2'd1;
        end
        AUT_STRING: begin
          r0 = mk(1, TK_STRING, 0, (ph_r == PH_END) ? ERR_NONE : ERR_STRING, lsl_r, 0);
          nres = 2'd1;
        end
        default: nres = 2'd0;
      endcase
      if (nres == 2'd0) r0 = mk(1, TK_END, 0, ERR_NONE, line_r, 0);
      else r1 = mk(1, TK_END, 0, ERR_NONE, line_r, 0);
      nres     = nres + 2'd1;
      aut_nxt  = AUT_START;
      trie_nxt = TRIE_INIT;
      ph_nxt   = PH_BEGIN;
      line_nxt = load_val;
    end else begin
      unique case (aut_r)
        AUT_UNKNOWN: begin
          if (d.other) used = 1'b1;
          else begin r0 = mk(1, TK_UNKNOWN, 0, ERR_NONE, lsl_r, 0); nres = 2'd1; end
        end
        AUT_ID: begin
          r0 = d.id_body ? mk(0, TK_IDENT, 0, ERR_NONE, lsl_r, d.ch)
                         : mk(1, TK_IDENT, 0, ERR_NONE, lsl_r, 0);
          nres = 2'd1;
          used = d.id_body;
        end
        AUT_KEYWORD: begin
          if (trie_r >= 8'(KW_STATES)) begin
            if (d.after_pct) begin
              used     = 1'b1;
              trie_nxt = d.init_state;
              pkc_nxt  = {~ie.exact, ie.kw};
            end else begin
              r0 = mk(1, TK_UNKNOWN, 0, ERR_PERCENT, lsl_r, 0); nres = 2'd1;
            end
          end else if (hit) begin
            used = 1'b1;
            if (hs < 8'(KW_STATES)) begin
              trie_nxt = hs;
              pkc_nxt  = {~he.exact, he.kw};
            end
          end else begin
            r0 = mk(1, TK_KEYWORD, pkc_r[4:0], pkc_r[5] ? ERR_KEYWORD : ERR_NONE, lsl_r, 0);
            nres = 2'd1;
          end
        end
        AUT_STRING: begin
          if (ph_r == PH_END) begin
            if (d.quote) begin
              r0 = mk(0, TK_STRING, 0, ERR_NONE, lsl_r, d.ch);
              ph_nxt = PH_BODY; used = 1'b1;
            end else r0 = mk(1, TK_STRING, 0, ERR_NONE, lsl_r, 0);
            nres = 2'd1;
          end else begin
            used = 1'b1;
            if (d.quote) ph_nxt = PH_END;
            else begin r0 = mk(0, TK_STRING, 0, ERR_NONE, lsl_r, d.ch); nres = 2'd1; end
          end
        end
        default: used = 1'b0;
      endcase
      if (!used) begin
        // reprocess the ending character in the start automaton
        aut_nxt  = AUT_START;
        ph_nxt   = PH_BEGIN;
        trie_nxt = TRIE_INIT;
        if (d.space) begin
          if (d.ch == CHAR_W'(10) && line_r != LINE_MAX) line_nxt = line_r + 1'b1;
        end else begin
          lsl_nxt = line_r;
          if (d.percent) aut_nxt = AUT_KEYWORD;
          else if (d.id_begin) begin
            aut_nxt = AUT_ID;
            r1 = mk(0, TK_IDENT, 0, ERR_NONE, line_r, d.ch);
          end else if (d.delim) begin
            r1 = mk(1, (d.ch == CHAR_W'(",")) ? TK_COMMA :
                       (d.ch == CHAR_W'(":")) ? TK_COLON :
                       (d.ch == CHAR_W'("{")) ? TK_LBRACE : TK_RBRACE,
                    0, ERR_NONE, line_r, 0);
          end else if (d.quote) begin
            aut_nxt = AUT_STRING;
            ph_nxt  = PH_BODY;
          end else aut_nxt = AUT_UNKNOWN;
          if (d.id_begin || d.delim) begin
            if (nres == 2'd0) r0 = r1;
            nres = nres + 2'd1;
          end
        end
      end
    end
    if (nres == 2'd1) r0.last_of_run = 1'b1;
    if (nres == 2'd2) r1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aut_r   <= AUT_START;
      ph_r    <= PH_BEGIN;
      trie_r  <= TRIE_INIT;
      pkc_r   <= '0;
      first_r <= 32'd1;
      line_r  <= LINE_BITS'(1);
      lsl_r   <= '0;
      ocnt_r  <= 2'd0;
    end else begin
      if (cfg_we) begin
        first_r <= cfg_wdata;
        line_r  <= (LINE_BITS >= 32) ? LINE_BITS'(cfg_wdata) :
                   ((cfg_wdata > 32'(LINE_MAX)) ? LINE_MAX : LINE_BITS'(cfg_wdata));
      end else if (step) line_r <= line_nxt;
      if (step) begin
        aut_r  <= aut_nxt;
        ph_r   <= ph_nxt;
        trie_r <= trie_nxt;
        pkc_r  <= pkc_nxt;
        lsl_r  <= lsl_nxt;
      end
      ocnt_r <= ocnt_r - {1'b0, pop_out} + (step ? nres : 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (step && ocnt_r == 2'd0) begin
      ob_r[0] <= r0;
      ob_r[1] <= r1;
    end else if (step) begin
      // one left and it is being taken
      ob_r[0] <= r0;
      ob_r[1] <= r1;
    end else if (pop_out) begin
      ob_r[0] <= ob_r[1];
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) ocnt_r <= 2'd2)
    else $error("output buffer overflow");
  assert property (@(posedge clk) disable iff (!rst_n) step |-> (ocnt_r - {1'b0, pop_out}) == 2'd0)
    else $error("step with results still pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    (step && d.is_end) |=> (aut_r == AUT_START && trie_r == TRIE_INIT))
    else $error("end of text did not return to start");

endmodule
`default_nettype wire
